### rtl/core/two_pole_resonant_filter_defines.svh
// Assertion macros used by the two-pole resonant filter checker.
`ifndef TWO_POLE_RESONANT_FILTER_DEFINES_SVH
`define TWO_POLE_RESONANT_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TPRF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tprf check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TPRF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tprf check failed");

`endif

### rtl/core/tprf_pkg.sv
// Constants and types of the two-pole resonant filter.
package tprf_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int HIST_BITS     = SAMPLE_BITS + 8;
	localparam int COEF_FRAC     = 16;
	localparam int FB1_BITS      = 19;
	localparam int FB2_BITS      = 17;
	localparam int GAIN_BITS     = 20;
	localparam int PROD_X_BITS   = GAIN_BITS + SAMPLE_BITS;
	localparam int ACC_BITS      = HIST_BITS + FB1_BITS + 2;
	localparam int RND_BITS      = ACC_BITS - COEF_FRAC;
	localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = FB1_BITS;

	localparam logic signed [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << COEF_FRAC);
	localparam logic signed [ACC_BITS-1:0]  RND_HALF = ACC_BITS'(1 << (COEF_FRAC - 1));

	localparam logic signed [HIST_BITS-1:0]   HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
	localparam logic signed [HIST_BITS-1:0]   HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FEEDBACK_ONE = 2'd0,
		REG_FEEDBACK_TWO = 2'd1
	} cfg_reg_t;

endpackage

### rtl/core/two_pole_resonant_filter.sv
// Two-pole resonant low-pass filter, DC-normalized, one sample per beat.
//
//  group   dir  payload (low bit up)                   beat taken when
//  s_axis  in   tdata: sample_in  tuser: frame_start   s_axis_tvalid & s_axis_tready
//  m_axis  out  tdata: sample_out tuser: clipped       m_axis_tvalid & m_axis_tready
//  cfg     in   cfg_index, cfg_data                    cfg_valid & cfg_ready
//
// One sample per cycle sustained while m_axis_tready stays high.
// Stage one registers g*x; stage two closes the g*x - a1*y1 - a2*y2 recursion through
// prev_q into the output register.
// Reset clears coefficients, history and both valid flags; gain resets to 1.0.
// A stalled output holds its beat; stage one takes one more beat, then s_axis_tready drops.
module two_pole_resonant_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [tprf_pkg::TDATA_BITS-1:0]     s_axis_tdata,  // [15:0] sample_in
	input  logic                                s_axis_tuser,  // [0] frame_start
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [tprf_pkg::TDATA_BITS-1:0]     m_axis_tdata,  // [15:0] sample_out
	output logic                                m_axis_tuser,  // [0] clipped
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tprf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tprf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	logic signed [tprf_pkg::FB1_BITS-1:0]    fb1_q;
	logic        [tprf_pkg::FB2_BITS-1:0]    fb2_q;
	logic signed [tprf_pkg::GAIN_BITS-1:0]   gain_q;

	logic                                    valid_s1;
	logic                                    fs_s1;
	logic signed [tprf_pkg::PROD_X_BITS-1:0] gx_s1;

	logic signed [tprf_pkg::HIST_BITS-1:0]   prev_q;
	logic signed [tprf_pkg::HIST_BITS-1:0]   prev_prev_q;

	logic                                    out_valid_q;
	logic        [tprf_pkg::SAMPLE_BITS-1:0] out_sample_q;
	logic                                    out_clip_q;

	logic                                    accept;
	logic                                    advance;
	logic signed [tprf_pkg::SAMPLE_BITS-1:0] x_in;
	logic signed [tprf_pkg::PROD_X_BITS-1:0] gx_c;
	logic signed [tprf_pkg::FB1_BITS-1:0]    cfg_fb1;
	logic signed [tprf_pkg::HIST_BITS-1:0]   y1;
	logic signed [tprf_pkg::HIST_BITS-1:0]   y2;
	logic signed [tprf_pkg::ACC_BITS-1:0]    p1;
	logic signed [tprf_pkg::ACC_BITS-1:0]    p2;
	logic signed [tprf_pkg::ACC_BITS-1:0]    acc;
	logic signed [tprf_pkg::RND_BITS-1:0]    rnd;
	logic signed [tprf_pkg::HIST_BITS-1:0]   y_hist;
	logic signed [tprf_pkg::SAMPLE_BITS-1:0] y_out;
	logic                                    y_clip;

	assign cfg_ready = 1'b1;
	assign cfg_fb1   = cfg_data[tprf_pkg::FB1_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb1_q  <= '0;
			fb2_q  <= '0;
			gain_q <= tprf_pkg::GAIN_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tprf_pkg::cfg_reg_t'(cfg_index))
				tprf_pkg::REG_FEEDBACK_ONE: begin
					fb1_q  <= cfg_fb1;
					gain_q <= tprf_pkg::GAIN_ONE
						+ tprf_pkg::GAIN_BITS'(cfg_fb1)
						+ tprf_pkg::GAIN_BITS'(fb2_q);
				end
				tprf_pkg::REG_FEEDBACK_TWO: begin
					fb2_q  <= cfg_data[tprf_pkg::FB2_BITS-1:0];
					gain_q <= tprf_pkg::GAIN_ONE
						+ tprf_pkg::GAIN_BITS'(fb1_q)
						+ tprf_pkg::GAIN_BITS'(cfg_data[tprf_pkg::FB2_BITS-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// handshake
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// stage one: input gain product
	assign x_in = s_axis_tdata[tprf_pkg::SAMPLE_BITS-1:0];
	assign gx_c = tprf_pkg::PROD_X_BITS'(gain_q) * tprf_pkg::PROD_X_BITS'(x_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gx_s1 <= gx_c;
			fs_s1 <= s_axis_tuser;
		end
	end

	// stage two: recursion, round, saturate
	assign y1  = fs_s1 ? '0 : prev_q;
	assign y2  = fs_s1 ? '0 : prev_prev_q;
	assign p1  = tprf_pkg::ACC_BITS'(fb1_q) * tprf_pkg::ACC_BITS'(y1);
	assign p2  = tprf_pkg::ACC_BITS'(signed'({1'b0, fb2_q})) * tprf_pkg::ACC_BITS'(y2);
	assign acc = tprf_pkg::ACC_BITS'(gx_s1) - p1 - p2 + tprf_pkg::RND_HALF;
	assign rnd = acc[tprf_pkg::ACC_BITS-1:tprf_pkg::COEF_FRAC];

	always_comb begin
		priority if (rnd > tprf_pkg::RND_BITS'(tprf_pkg::HIST_MAX)) begin
			y_hist = tprf_pkg::HIST_MAX;
		end else if (rnd < tprf_pkg::RND_BITS'(tprf_pkg::HIST_MIN)) begin
			y_hist = tprf_pkg::HIST_MIN;
		end else begin
			y_hist = rnd[tprf_pkg::HIST_BITS-1:0];
		end
	end

	always_comb begin
		priority if (y_hist > tprf_pkg::HIST_BITS'(tprf_pkg::SAMP_MAX)) begin
			y_out  = tprf_pkg::SAMP_MAX;
			y_clip = 1'b1;
		end else if (y_hist < tprf_pkg::HIST_BITS'(tprf_pkg::SAMP_MIN)) begin
			y_out  = tprf_pkg::SAMP_MIN;
			y_clip = 1'b1;
		end else begin
			y_out  = y_hist[tprf_pkg::SAMPLE_BITS-1:0];
			y_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			prev_prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				prev_q      <= y_hist;
				prev_prev_q <= y1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= y_out;
			out_clip_q   <= y_clip;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tprf_pkg::TDATA_BITS'(out_sample_q);
	assign m_axis_tuser  = out_clip_q;

endmodule

### rtl/core/tprf_checker.sv
// Port-level checks of the two-pole resonant filter, bound to the top level.
`include "two_pole_resonant_filter_defines.svh"

module tprf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [tprf_pkg::TDATA_BITS-1:0]     m_axis_tdata,
	input logic                                m_axis_tuser,
	input logic                                cfg_valid,
	input logic                                cfg_ready
);

	logic in_beat;
	logic [tprf_pkg::SAMPLE_BITS-1:0] out_sample;

	assign in_beat    = s_axis_tvalid && s_axis_tready;
	assign out_sample = m_axis_tdata[tprf_pkg::SAMPLE_BITS-1:0];

	// a stalled output beat holds
	`TPRF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata) && $stable(m_axis_tuser))

	// clipped output sits on a rail
	`TPRF_ASSERT_NOW(a_clip_rail, m_axis_tvalid && m_axis_tuser,
		out_sample == tprf_pkg::SAMPLE_BITS'(tprf_pkg::SAMP_MAX)
		|| out_sample == tprf_pkg::SAMPLE_BITS'(tprf_pkg::SAMP_MIN))

	// a fresh output beat follows an input beat through stage one and the output register
	`TPRF_ASSERT_NOW(a_out_latency, $rose(m_axis_tvalid), $past(in_beat, 2))

	// configuration writes are never back-pressured
	`TPRF_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind two_pole_resonant_filter tprf_checker u_tprf_checker (.*);
